// ----- sv/utf8_message_validator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// UTF-8 message validator: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_MESSAGE_VALIDATOR_UNIT_DEFINES_SVH
`define UTF8_MESSAGE_VALIDATOR_UNIT_DEFINES_SVH

// antecedent holds now, consequent holds in the same cycle
`define UMV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("umv: same-cycle check failed");

// antecedent holds now, consequent holds in the next cycle
`define UMV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("umv: next-cycle check failed");

`endif

// ----- sv/umv_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 message validator package
// Widths, limits and status codes shared by the validator and its checker.
// ----------------------------------------------------------------------------
package umv_pkg;

	localparam int LENGTH_BITS = 13;                 // internal byte counter width
	localparam int CFG_BITS    = 13;                 // max_length register width
	localparam int OUT_BITS    = 13;                 // message_length port width
	localparam int CMP_BITS    = ((LENGTH_BITS > CFG_BITS) ? LENGTH_BITS : CFG_BITS) + 1;
	localparam int CNT_MAX     = (2 ** LENGTH_BITS) - 1;
	localparam int OUT_MAX     = (2 ** OUT_BITS) - 1;
	localparam int MAX_LENGTH_RESET = 256;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_BAD_UTF8 = 3'd3,
		ST_BAD_CHAR = 3'd4
	} status_t;

endpackage

// ----- sv/utf8_message_validator_unit.sv -----
// ----------------------------------------------------------------------------
// UTF-8 message validator
// Strict UTF-8 decode, length limit and control character check per message.
// ----------------------------------------------------------------------------
// Path: the byte that ends a message passes the input register, then the
// result register, which drives the result channel.
// Throughput: one byte per cycle; the decode step between the two registers
// sets this figure. A stalled result holds only a message-ending byte back.
// Reset: all message state and both valids clear, max_length returns to 256.
module utf8_message_validator_unit
	import umv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// byte channel
	input  logic                data_valid,
	output logic                data_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                empty_msg,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [2:0]          status,
	output logic [OUT_BITS-1:0] message_length,
	// configuration write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] max_length
);

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   empty_s1;

	// message state
	logic [CFG_BITS-1:0]    max_length_q;
	logic [1:0]             cont_q;
	logic [20:0]            pcp_q;
	logic [2:0]             seq_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic                   too_long_q;
	logic                   bad_utf8_q;
	logic                   bad_char_q;

	// result register
	logic                   res_valid_q;
	status_t                res_status_q;
	logic [OUT_BITS-1:0]    res_len_q;

	// next-state values
	logic [1:0]             cont_nx;
	logic [20:0]            pcp_nx;
	logic [20:0]            cp_fin;
	logic [2:0]             seq_nx;
	logic [LENGTH_BITS-1:0] count_nx;
	logic                   too_long_nx;
	logic                   bad_utf8_nx;
	logic                   bad_char_nx;
	logic                   bad_utf8_fin;
	logic [CMP_BITS-1:0]    cnt_inc;
	logic [CMP_BITS-1:0]    cap;
	logic [CMP_BITS-1:0]    cnt_nx_ext;
	status_t                status_nx;
	logic [OUT_BITS-1:0]    len_nx;

	logic                   ends_msg;
	logic                   out_free;
	logic                   advance;

	assign ends_msg   = empty_s1 | last_s1;
	assign out_free   = ~res_valid_q | ~result_stall;
	assign advance    = valid_s1 & (~ends_msg | out_free);
	assign data_stall = valid_s1 & ~advance;
	assign cfg_ready  = 1'b1;

	// length count
	always_comb begin
		cnt_inc     = CMP_BITS'(count_q) + CMP_BITS'(1);
		too_long_nx = too_long_q | (cnt_inc > CMP_BITS'(max_length_q));
		cap         = CMP_BITS'(max_length_q) + CMP_BITS'(1);
		if (cap > CMP_BITS'(CNT_MAX)) begin
			cap = CMP_BITS'(CNT_MAX);
		end
		cnt_nx_ext  = (cnt_inc <= cap) ? cnt_inc : cap;
		count_nx    = cnt_nx_ext[LENGTH_BITS-1:0];
		if (cnt_nx_ext > CMP_BITS'(OUT_MAX)) begin
			len_nx = OUT_BITS'(OUT_MAX);
		end else begin
			len_nx = cnt_nx_ext[OUT_BITS-1:0];
		end
	end

	// control characters: everything below space but tab
	assign bad_char_nx = bad_char_q | ((byte_s1 < 8'h20) & (byte_s1 != 8'h09));

	// decode step
	always_comb begin
		cont_nx     = cont_q;
		pcp_nx      = pcp_q;
		seq_nx      = seq_q;
		bad_utf8_nx = bad_utf8_q;
		cp_fin      = {pcp_q[14:0], byte_s1[5:0]};
		if (bad_utf8_q) begin
			cont_nx = 2'd0;
		end else if (cont_q == 2'd0) begin
			case (byte_s1) inside
				[8'h00:8'h7F]: begin
				end
				[8'hC2:8'hDF]: begin
					seq_nx  = 3'd2;
					pcp_nx  = {16'd0, byte_s1[4:0]};
					cont_nx = 2'd1;
				end
				[8'hE0:8'hEF]: begin
					seq_nx  = 3'd3;
					pcp_nx  = {17'd0, byte_s1[3:0]};
					cont_nx = 2'd2;
				end
				[8'hF0:8'hF4]: begin
					seq_nx  = 3'd4;
					pcp_nx  = {18'd0, byte_s1[2:0]};
					cont_nx = 2'd3;
				end
				default: begin
					bad_utf8_nx = 1'b1;
				end
			endcase
		end else if (byte_s1[7:6] != 2'b10) begin
			bad_utf8_nx = 1'b1;
			cont_nx     = 2'd0;
		end else begin
			pcp_nx  = cp_fin;
			cont_nx = cont_q - 2'd1;
			// sequence complete: overlong, range and surrogate checks
			if (cont_nx == 2'd0) begin
				if (((seq_q == 3'd3) && (cp_fin < 21'h800)) ||
				    ((seq_q == 3'd4) && (cp_fin < 21'h10000)) ||
				    (cp_fin > 21'h10FFFF) ||
				    ((cp_fin >= 21'hD800) && (cp_fin <= 21'hDFFF))) begin
					bad_utf8_nx = 1'b1;
				end
			end
		end
	end

	// a sequence cut off by the last byte
	assign bad_utf8_fin = bad_utf8_nx | (cont_nx != 2'd0);

	always_comb begin
		if (too_long_nx) begin
			status_nx = ST_TOO_LONG;
		end else if (bad_utf8_fin) begin
			status_nx = ST_BAD_UTF8;
		end else if (bad_char_nx) begin
			status_nx = ST_BAD_CHAR;
		end else begin
			status_nx = ST_OK;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= CFG_BITS'(MAX_LENGTH_RESET);
		end else if (cfg_valid && cfg_ready) begin
			max_length_q <= max_length;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1  <= data_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_msg;
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q     <= 2'd0;
			pcp_q      <= 21'd0;
			seq_q      <= 3'd0;
			count_q    <= '0;
			too_long_q <= 1'b0;
			bad_utf8_q <= 1'b0;
			bad_char_q <= 1'b0;
		end else if (advance) begin
			if (ends_msg) begin
				cont_q     <= 2'd0;
				pcp_q      <= 21'd0;
				seq_q      <= 3'd0;
				count_q    <= '0;
				too_long_q <= 1'b0;
				bad_utf8_q <= 1'b0;
				bad_char_q <= 1'b0;
			end else begin
				cont_q     <= cont_nx;
				pcp_q      <= pcp_nx;
				seq_q      <= seq_nx;
				count_q    <= count_nx;
				too_long_q <= too_long_nx;
				bad_utf8_q <= bad_utf8_nx;
				bad_char_q <= bad_char_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && ends_msg) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ends_msg) begin
			if (empty_s1) begin
				res_status_q <= ST_EMPTY;
				res_len_q    <= '0;
			end else begin
				res_status_q <= status_nx;
				res_len_q    <= len_nx;
			end
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = res_status_q;
	assign message_length = res_len_q;

endmodule

// ----- sv/umv_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 message validator checker
// Port-level assertions on the result channel, bound into the validator module.
// ----------------------------------------------------------------------------
`include "utf8_message_validator_unit_defines.svh"

module umv_checker
	import umv_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                data_valid,
	input logic                data_stall,
	input logic [7:0]          data_byte,
	input logic                last_byte,
	input logic                empty_msg,
	input logic                result_valid,
	input logic                result_stall,
	input logic [2:0]          status,
	input logic [OUT_BITS-1:0] message_length,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [CFG_BITS-1:0] max_length
);

	// a stalled result stays offered and unchanged
	`UMV_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)
	`UMV_ASSERT_NEXT(a_res_stable, result_valid && result_stall,
		$stable(status) && $stable(message_length))

	// empty messages report no length, good ones report some
	`UMV_ASSERT_NOW(a_empty_len, result_valid && (status == ST_EMPTY),
		message_length == '0)
	`UMV_ASSERT_NOW(a_ok_len, result_valid && (status == ST_OK),
		message_length != '0)

	`UMV_ASSERT_NOW(a_status_code, result_valid,
		(status == ST_OK) || (status == ST_EMPTY) || (status == ST_TOO_LONG) ||
		(status == ST_BAD_UTF8) || (status == ST_BAD_CHAR))

endmodule

bind utf8_message_validator_unit umv_checker u_umv_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// UTF-8 message validator testbench
// Sends whole messages as a byte stream, both well-formed text and text with
// planted faults. A scoreboard predicts each message's status and length and
// checks every result. Both channels idle at random, and the length limit is
// changed between phases.
// ----------------------------------------------------------------------------
import umv_pkg::*;

typedef struct {
	status_t                 st;
	logic [OUT_BITS-1:0]     len;
} verdict_t;

class validation_board;
	localparam logic [7:0]  LEAD2_MIN  = 8'hC2;
	localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
	localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
	localparam logic [7:0]  LEAD3_MAX  = 8'hEF;
	localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
	localparam logic [7:0]  LEAD4_MAX  = 8'hF4;
	localparam logic [7:0]  ASCII_MAX  = 8'h7F;
	localparam logic [7:0]  CTRL_LIMIT = 8'h20;
	localparam logic [7:0]  TAB        = 8'h09;
	localparam logic [1:0]  CONT_TAG   = 2'b10;
	localparam logic [20:0] MIN3       = 21'h000800;
	localparam logic [20:0] MIN4       = 21'h010000;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;

	verdict_t               pending[$];
	logic [CFG_BITS-1:0]    limit;
	logic [1:0]             conts_left;
	logic [20:0]            code_acc;
	logic [2:0]             seq_len;
	logic [LENGTH_BITS-1:0] count;
	bit                     too_long;
	bit                     bad_utf8;
	bit                     bad_char;
	int                     fail_count;
	int                     seen[5];

	function new();
		limit = CFG_BITS'(MAX_LENGTH_RESET);
		fail_count = 0;
		clear_message();
	endfunction

	function void clear_message();
		conts_left = '0;
		code_acc = '0;
		seq_len = '0;
		count = '0;
		too_long = 0;
		bad_utf8 = 0;
		bad_char = 0;
	endfunction

	// Note an accepted byte channel item; queue a verdict when a message ends
	function void note_item(logic [7:0] b, bit last, bit empty);
		verdict_t v;
		int       cap;
		if (empty) begin
			clear_message();
			v.st = ST_EMPTY;
			v.len = '0;
			pending.insert(pending.size(), v);
			return;
		end
		// limit compared against the saturated count
		if (int'(count) + 1 > int'(limit))
			too_long = 1;
		cap = int'(limit) + 1;
		if (cap > CNT_MAX)
			cap = CNT_MAX;
		if (int'(count) + 1 <= cap)
			count = count + 1'b1;
		else
			count = LENGTH_BITS'(cap);
		if (b < CTRL_LIMIT && b != TAB)
			bad_char = 1;

		if (bad_utf8) begin
			conts_left = '0;
		end else if (conts_left == 0) begin
			if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				seq_len = 3'd2;
				code_acc = {16'd0, b[4:0]};
				conts_left = 2'd1;
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				seq_len = 3'd3;
				code_acc = {17'd0, b[3:0]};
				conts_left = 2'd2;
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				seq_len = 3'd4;
				code_acc = {18'd0, b[2:0]};
				conts_left = 2'd3;
			end else if (b > ASCII_MAX) begin
				bad_utf8 = 1;
			end
		end else if (b[7:6] != CONT_TAG) begin
			bad_utf8 = 1;
			conts_left = '0;
		end else begin
			code_acc = {code_acc[14:0], b[5:0]};
			conts_left = conts_left - 2'd1;
			if (conts_left == 0 && ((seq_len == 3'd3 && code_acc < MIN3) ||
					(seq_len == 3'd4 && code_acc < MIN4) || code_acc > CP_MAX ||
					(code_acc >= SURR_LO && code_acc <= SURR_HI)))
				bad_utf8 = 1;
		end

		if (!last)
			return;
		// sequence cut off by the end of the message
		if (conts_left != 0)
			bad_utf8 = 1;
		if (too_long)
			v.st = ST_TOO_LONG;
		else if (bad_utf8)
			v.st = ST_BAD_UTF8;
		else if (bad_char)
			v.st = ST_BAD_CHAR;
		else
			v.st = ST_OK;
		v.len = (int'(count) > OUT_MAX) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(count);
		pending.insert(pending.size(), v);
		clear_message();
	endfunction

	task report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task check_result(logic [2:0] st, logic [OUT_BITS-1:0] len);
		verdict_t v;
		if (pending.size() == 0) begin
			report_mismatch($sformatf("result status %0d length %0d with no message waiting",
				st, len));
			return;
		end
		v = pending[0];
		pending.delete(0);
		seen[int'(v.st)]++;
		if (st !== v.st)
			report_mismatch($sformatf("status %0d, expected %s", st, v.st.name()));
		if (len !== v.len)
			report_mismatch($sformatf("message_length %0d, expected %0d", len, v.len));
	endtask
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_TOTAL   = 1550;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 600000;

	logic                clk;
	logic                arst_n;
	logic                data_valid;
	logic                data_stall;
	logic [7:0]          data_byte;
	logic                last_byte;
	logic                empty_msg;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [2:0]          status;
	logic [OUT_BITS-1:0] message_length;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] max_length;

	validation_board board;
	logic [7:0]      msg_bytes[$];
	int unsigned     limits[$];
	int unsigned     cp_marks[8] = '{'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF,
		'h10000, 'h10FFFF};
	int              phase_items;
	int              byte_total;
	bit              send_steady;
	bit              take_steady = 0;
	int              hold = 0;
	int unsigned     cycle_count = 0;

	utf8_message_validator_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL utf8_message_validator_unit");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && data_valid && !data_stall)
			board.note_item(data_byte, last_byte, empty_msg);

	// result side: stall drawn per item, held while the result waits
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			board.check_result(status, message_length);
			if ($urandom_range(0, 15) == 0)
				take_steady = !take_steady;
			hold = take_steady ? 0 : $urandom_range(0, 4);
		end else if (result_valid && hold > 0) begin
			hold--;
		end
		result_stall <= (hold > 0);
	end

	task automatic send_item(logic [7:0] b, bit last, bit empty);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		empty_msg <= empty;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		phase_items++;
		byte_total++;
	endtask

	task automatic wait_idle();
		data_valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(int unsigned v);
		cfg_valid <= 1'b1;
		max_length <= CFG_BITS'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.limit = CFG_BITS'(v);
		cfg_valid <= 1'b0;
	endtask

	function automatic void put_byte(logic [7:0] b);
		msg_bytes.insert(msg_bytes.size(), b);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic void add_cp(int unsigned cp);
		if (cp < 'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 'h800) begin
			put_byte(8'hC0 | cp[10:6]);
			put_byte(8'h80 | cp[5:0]);
		end else if (cp < 'h10000) begin
			put_byte(8'hE0 | cp[15:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end else begin
			put_byte(8'hF0 | cp[20:18]);
			put_byte(8'h80 | cp[17:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end
	endfunction

	function automatic void add_clean_char();
		int unsigned cp;
		case ($urandom_range(0, 9))
			5: add_cp($urandom_range('h80, 'h7FF));
			6: begin
				cp = $urandom_range('h800, 'hFFFF);
				if (cp >= 'hD800 && cp <= 'hDFFF)
					cp -= 'h800;
				add_cp(cp);
			end
			7: add_cp($urandom_range('h10000, 'h10FFFF));
			8: add_cp(cp_marks[$urandom_range(0, 7)]);
			default: put_byte(($urandom_range(0, 15) == 0) ? 8'h09 :
				8'($urandom_range('h20, 'h7F)));
		endcase
	endfunction

	// lead byte followed by too few continuations
	function automatic void add_cut_sequence();
		logic [7:0] b;
		int         n;
		b = 8'($urandom_range('hC2, 'hF4));
		n = (b >= 8'hF0) ? 3 : (b >= 8'hE0) ? 2 : 1;
		put_byte(b);
		repeat ($urandom_range(0, n - 1))
			put_byte(cont_byte());
	endfunction

	function automatic void add_fault();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: begin
				b = 8'($urandom_range(0, 31));
				if (b == 8'h09)
					b = 8'h0A;
				put_byte(b);
			end
			1: put_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1)) :
				8'($urandom_range('hF5, 'hFF)));
			2: begin
				put_byte(8'hE0);
				put_byte(8'($urandom_range('h80, 'h9F)));
				put_byte(cont_byte());
			end
			3: begin
				put_byte(8'hF0);
				put_byte(8'($urandom_range('h80, 'h8F)));
				put_byte(cont_byte());
				put_byte(cont_byte());
			end
			4: add_cp($urandom_range('hD800, 'hDFFF));
			5: begin
				put_byte(8'hF4);
				put_byte(8'($urandom_range('h90, 'hBF)));
				put_byte(cont_byte());
				put_byte(cont_byte());
			end
			6: begin
				add_cut_sequence();
				put_byte(8'($urandom_range('h20, 'h7E)));
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					put_byte(cont_byte());
				end else begin
					put_byte(8'hE2);
					put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F)) :
						8'($urandom_range('hC0, 'hFF)));
				end
			end
		endcase
	endfunction

	function automatic void build_message(int target, bit faulty);
		bit hit;
		hit = 0;
		msg_bytes.delete();
		while (msg_bytes.size() + 4 <= target) begin
			if (faulty && $urandom_range(0, 4) == 0) begin
				add_fault();
				hit = 1;
			end else begin
				add_clean_char();
			end
		end
		while (msg_bytes.size() < target)
			put_byte(8'($urandom_range('h20, 'h7E)));
		if (faulty && !hit)
			add_fault();
		if (faulty && $urandom_range(0, 3) == 0)
			add_cut_sequence();
	endfunction

	// sends msg_bytes; now and then an empty marker lands mid-message
	task automatic send_message(bit may_split);
		int split;
		split = -1;
		send_steady = ($urandom_range(0, 4) == 0);
		if (may_split && msg_bytes.size() > 1 && $urandom_range(0, 19) == 0)
			split = $urandom_range(1, msg_bytes.size() - 1);
		foreach (msg_bytes[i]) begin
			if (i == split)
				send_item(8'($urandom), 1'($urandom), 1'b1);
			send_item(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0);
		end
	endtask

	task automatic run_phase(int budget);
		int lim;
		int target;
		int r;
		bit paused;
		phase_items = 0;
		paused = 0;
		while (phase_items < budget) begin
			// hold the sender back until the block has emptied
			if (!paused && phase_items >= budget / 2) begin
				wait_idle();
				paused = 1;
			end
			lim = int'(board.limit);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_steady = 0;
				send_item(8'($urandom), 1'($urandom), 1'b1);
				continue;
			end
			if (r < 14) begin
				msg_bytes.delete();
				repeat ($urandom_range(1, 12))
					put_byte(8'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: target = $urandom_range(1, 12);
					6, 7: target = $urandom_range(1, 40);
					default: target = (lim <= 300) ?
						$urandom_range((lim > 2) ? lim - 2 : 1, lim + 2) : $urandom_range(1, 60);
				endcase
				build_message(target, r >= 60);
			end
			send_message(1'b1);
		end
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		empty_msg = 1'b0;
		cfg_valid = 1'b0;
		max_length = CFG_BITS'(MAX_LENGTH_RESET);
		send_steady = 0;
		byte_total = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset limit
		msg_bytes = '{8'h41};
		send_message(1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		msg_bytes = '{8'hC1};
		send_message(1'b0);
		msg_bytes = '{8'h0D};
		send_message(1'b0);
		msg_bytes = '{8'hE0, 8'h9F, 8'hBF};
		send_message(1'b0);
		msg_bytes = '{8'hED, 8'hA0, 8'h80};
		send_message(1'b0);
		msg_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
		send_message(1'b0);
		msg_bytes = '{8'hF0, 8'h8F, 8'hBF, 8'hBF};
		send_message(1'b0);
		msg_bytes = '{8'hC3};
		send_message(1'b0);
		send_item(8'h41, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		// decoder error ahead of a line feed: bad UTF-8 wins
		msg_bytes = '{8'hFF, 8'h0A};
		send_message(1'b0);
		wait_idle();

		limits = '{0, 1, 4096, 2, 4095, 23, 256};
		limits.insert(limits.size(), $urandom_range(1, 4096));
		limits.insert(limits.size(), $urandom_range(3, 40));
		foreach (limits[k]) begin
			write_limit(limits[k]);
			run_phase(ITEMS_TOTAL / limits.size());
			wait_idle();
		end

		$display("%0d byte channel items over %0d length limits, 0 to 4096",
			byte_total, limits.size() + 1);
		$display("verdicts: ok %0d, empty %0d, too long %0d, bad utf-8 %0d, control %0d",
			board.seen[0], board.seen[1], board.seen[2], board.seen[3], board.seen[4]);
		if (board.fail_count == 0)
			$display("PASS utf8_message_validator_unit");
		else
			$display("FAIL utf8_message_validator_unit");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/umv_pkg.sv
sv/utf8_message_validator_unit.sv
sv/umv_checker.sv
test/testbench.sv
